/* rtl/core/gtpg_pkg.sv */
// Shared types, constants and helpers for the grid test-pattern generator.
// No dependencies; used by gtpg_iter_unit and grid_test_pattern_generator.
package gtpg_pkg;

    // Field and register widths
    localparam int COORD_W     = 11;
    localparam int CELLS_W     = 8;
    localparam int COLOR_W     = 24;
    localparam int STEP_W      = 8;
    localparam int CHW_W       = 12;
    localparam int CHAN_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_SIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INDEXED_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_WIDTHS = 3'd6;

    // Iterative unit operations and step counts
    localparam logic OP_DIV = 1'b0;
    localparam logic OP_MUL = 1'b1;
    localparam int   DIV_STEPS = COORD_W;
    localparam int   MUL_STEPS = CHAN_W;
    localparam int   STEP_CNT_W = 4;

    // Request into the shared divide / multiply unit
    typedef struct packed {
        logic               start;
        logic               op;
        logic [COORD_W-1:0] opa;
        logic [CHAN_W-1:0]  opb;
    } unit_req_t;

    // Response from the shared unit
    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] result;
    } unit_rsp_t;

    // Clamp a channel width nibble to at most 8 bits
    function automatic logic [3:0] chan_width(input logic [3:0] nib);
        chan_width = (nib > 4'd8) ? 4'd8 : nib;
    endfunction

    // Low mask with the given number of ones (0..8)
    function automatic logic [CHAN_W-1:0] chan_mask(input logic [3:0] bits);
        logic [CHAN_W:0] full;
        full = (9'd1 << bits) - 9'd1;
        chan_mask = full[CHAN_W-1:0];
    endfunction

endpackage

/* rtl/core/gtpg_iter_unit.sv */
// Shared bit-serial arithmetic unit: restoring divide (11-bit by 8-bit)
// or shift-add multiply modulo 256, one bit per cycle. Depends on gtpg_pkg.
module gtpg_iter_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gtpg_pkg::unit_req_t   req,
    output gtpg_pkg::unit_rsp_t   rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic                                op_reg;
    logic [gtpg_pkg::STEP_CNT_W-1:0]     cnt_reg;
    logic [gtpg_pkg::COORD_W-1:0]        work_reg;
    logic [gtpg_pkg::CHAN_W-1:0]         rem_reg;
    logic [gtpg_pkg::CHAN_W-1:0]         opb_reg;
    logic [gtpg_pkg::CHAN_W-1:0]         mcand_reg;

    logic [gtpg_pkg::CHAN_W:0]           trial;
    logic [gtpg_pkg::CHAN_W:0]           diff;
    logic                                fits;
    logic [gtpg_pkg::CHAN_W-1:0]         acc_sum;

    // One restoring-divide step and one shift-add step
    always_comb begin
        trial   = {rem_reg, work_reg[gtpg_pkg::COORD_W-1]};
        fits    = trial >= {1'b0, opb_reg};
        diff    = trial - {1'b0, opb_reg};
        acc_sum = work_reg[gtpg_pkg::CHAN_W-1:0] + (opb_reg[0] ? mcand_reg : '0);
    end

    // Control: busy and completion pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: load operands, then advance one bit a cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            op_reg    <= req.op;
            rem_reg   <= '0;
            opb_reg   <= req.opb;
            mcand_reg <= req.opa[gtpg_pkg::CHAN_W-1:0];
            if (req.op == gtpg_pkg::OP_DIV) begin
                work_reg <= req.opa;
                cnt_reg  <= gtpg_pkg::STEP_CNT_W'(gtpg_pkg::DIV_STEPS - 1);
            end else begin
                work_reg <= '0;
                cnt_reg  <= gtpg_pkg::STEP_CNT_W'(gtpg_pkg::MUL_STEPS - 1);
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (op_reg == gtpg_pkg::OP_DIV) begin
                rem_reg  <= fits ? diff[gtpg_pkg::CHAN_W-1:0]
                                 : trial[gtpg_pkg::CHAN_W-1:0];
                work_reg <= {work_reg[gtpg_pkg::COORD_W-2:0], fits};
            end else begin
                work_reg  <= gtpg_pkg::COORD_W'(acc_sum);
                mcand_reg <= {mcand_reg[gtpg_pkg::CHAN_W-2:0], 1'b0};
                opb_reg   <= {1'b0, opb_reg[gtpg_pkg::CHAN_W-1:1]};
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = work_reg;

endmodule

/* rtl/core/grid_test_pattern_generator.sv */
// Grid test-pattern generator top level: sequencer, counters, color logic.
// Depends on gtpg_pkg and gtpg_iter_unit.
//
// Usage:
//   Each request on the s_ channel (s_tdata[0] = restart) produces one pixel on
//   the m_ channel, in row-major order over a frame of frame_width by
//   frame_height. The user writes registers through cfg_we / cfg_index / cfg_data
//   only while the block is idle; the block itself does not enforce this.
//   After acceptance a small sequencer drives the shared bit-serial unit. A
//   pixel outside the grid goes from the cell check to the final step; inside
//   the grid two 8-step multiplies come in between, and a frame-start pixel
//   with nonzero cells-per-side first runs the two 11-step cell-size divides.
//   s_tready is high only while the sequencer is idle; one item is in work at
//   a time.
//   The result sits in an output register: a new request is accepted while a
//   pixel waits for m_tready, and its work stops before the output stage until
//   the receiver takes the waiting pixel.
//   Reset (aresetn low, synchronous) loads the register defaults, clears the
//   raster position and cell sizes and empties the output register.
module grid_test_pattern_generator #(
    parameter int INDEX_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,    // [0] restart
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,    // [10:0] pixel_x,
                                                          // [21:11] pixel_y,
                                                          // [45:22] pixel_color
    output logic                              m_tlast,    // line_end
    output logic [1:0]                        m_tuser,    // [0] inside_grid,
                                                          // [1] frame_end
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [gtpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gtpg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW = gtpg_pkg::COORD_W;
    localparam int NW = gtpg_pkg::CELLS_W;
    localparam int KW = gtpg_pkg::COLOR_W;
    localparam int HW = gtpg_pkg::CHAN_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV_W = 3'd1;
    localparam logic [2:0] ST_DIV_H = 3'd2;
    localparam logic [2:0] ST_CELL  = 3'd3;
    localparam logic [2:0] ST_MUL_A = 3'd4;
    localparam logic [2:0] ST_MUL_B = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    // Configuration registers
    logic [CW-1:0]                 fw_reg;
    logic [CW-1:0]                 fh_reg;
    logic [NW-1:0]                 cps_reg;
    logic [KW-1:0]                 first_reg;
    logic [gtpg_pkg::STEP_W-1:0]   step_reg;
    logic                          indexed_reg;
    logic [gtpg_pkg::CHW_W-1:0]    chw_reg;

    // Raster state
    logic [CW-1:0]  col_reg, row_reg;
    logic [CW-1:0]  cw_reg, ch_reg;
    logic [CW-1:0]  ox_reg, oy_reg;
    logic [NW-1:0]  gc_reg, gr_reg;

    // Sequencer and working registers
    logic [2:0]     state_reg, state_next;
    logic           inside_reg;
    logic [HW-1:0]  p1_reg, p2_reg;

    // Output register
    logic           m_tvalid_reg;
    logic [CW-1:0]  out_x_reg, out_y_reg;
    logic [KW-1:0]  out_color_reg;
    logic           out_inside_reg, out_lend_reg, out_fend_reg;

    gtpg_pkg::unit_req_t unit_req;
    gtpg_pkg::unit_rsp_t unit_rsp;

    logic             accept;
    logic             at_origin;
    logic             inside_now;
    logic             out_free;
    logic             lend, fend;
    logic [CW-1:0]    ox_inc, oy_inc;
    logic [3:0]       rw, gw, bw;
    logic [4:0]       sh_r, sh_g;
    logic [HW-1:0]    r0, g0, b0, r_val, g_val, b_val;
    logic [KW-1:0]    rgb_color;
    logic [INDEX_BITS-1:0] idx_sum;
    logic [KW-1:0]    color_val;

    // Shared divide / multiply unit
    gtpg_iter_unit u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .rsp     (unit_rsp)
    );

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign at_origin = s_tdata[0] || (col_reg == '0 && row_reg == '0);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign inside_now = (cw_reg != '0) && (ch_reg != '0) &&
                        (gc_reg < cps_reg) && (gr_reg < cps_reg);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg      <= 11'd800;
            fh_reg      <= 11'd600;
            cps_reg     <= 8'd1;
            first_reg   <= '0;
            step_reg    <= 8'd1;
            indexed_reg <= 1'b0;
            chw_reg     <= 12'h565;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gtpg_pkg::REG_FRAME_WIDTH:    fw_reg      <= cfg_data[CW-1:0];
                gtpg_pkg::REG_FRAME_HEIGHT:   fh_reg      <= cfg_data[CW-1:0];
                gtpg_pkg::REG_CELLS_PER_SIDE: cps_reg     <= cfg_data[NW-1:0];
                gtpg_pkg::REG_FIRST_COLOR:    first_reg   <= cfg_data[KW-1:0];
                gtpg_pkg::REG_COLOR_STEP:     step_reg    <= cfg_data[gtpg_pkg::STEP_W-1:0];
                gtpg_pkg::REG_INDEXED_MODE:   indexed_reg <= cfg_data[0];
                gtpg_pkg::REG_CHANNEL_WIDTHS: chw_reg     <= cfg_data[gtpg_pkg::CHW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer next state and unit requests
    always_comb begin
        state_next     = state_reg;
        unit_req.start = 1'b0;
        unit_req.op    = gtpg_pkg::OP_DIV;
        unit_req.opa   = fw_reg;
        unit_req.opb   = cps_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (at_origin && cps_reg != '0) begin
                        unit_req.start = 1'b1;
                        state_next     = ST_DIV_W;
                    end else begin
                        state_next = ST_CELL;
                    end
                end
            end
            ST_DIV_W: begin
                if (unit_rsp.done) begin
                    unit_req.start = 1'b1;
                    unit_req.opa   = fh_reg;
                    state_next     = ST_DIV_H;
                end
            end
            ST_DIV_H: begin
                if (unit_rsp.done) begin
                    state_next = ST_CELL;
                end
            end
            ST_CELL: begin
                if (inside_now) begin
                    unit_req.start = 1'b1;
                    unit_req.op    = gtpg_pkg::OP_MUL;
                    unit_req.opa   = indexed_reg ? CW'(gr_reg) : CW'(gc_reg);
                    unit_req.opb   = indexed_reg ? cps_reg : step_reg;
                    state_next     = ST_MUL_A;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL_A: begin
                unit_req.op  = gtpg_pkg::OP_MUL;
                unit_req.opa = indexed_reg
                             ? CW'(unit_rsp.result[HW-1:0] + gc_reg)
                             : CW'(gr_reg);
                unit_req.opb = step_reg;
                if (unit_rsp.done) begin
                    unit_req.start = 1'b1;
                    state_next     = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                if (unit_rsp.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold cell sizes, products and the inside flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= '0;
            ch_reg <= '0;
        end else begin
            if (state_reg == ST_IDLE && accept && at_origin && cps_reg == '0) begin
                cw_reg <= '0;
                ch_reg <= '0;
            end
            if (state_reg == ST_DIV_W && unit_rsp.done) begin
                cw_reg <= unit_rsp.result;
            end
            if (state_reg == ST_DIV_H && unit_rsp.done) begin
                ch_reg <= unit_rsp.result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CELL) begin
            inside_reg <= inside_now;
        end
        if (state_reg == ST_MUL_A && unit_rsp.done) begin
            p1_reg <= unit_rsp.result[HW-1:0];
        end
        if (state_reg == ST_MUL_B && unit_rsp.done) begin
            p2_reg <= unit_rsp.result[HW-1:0];
        end
    end

    // Row and frame ends
    assign lend   = ({1'b0, col_reg} + 12'd1) >= {1'b0, fw_reg};
    assign fend   = lend && (({1'b0, row_reg} + 12'd1) >= {1'b0, fh_reg});
    assign ox_inc = ox_reg + 1'b1;
    assign oy_inc = oy_reg + 1'b1;

    // Indexed color
    assign idx_sum = first_reg[INDEX_BITS-1:0] + p2_reg[INDEX_BITS-1:0];

    // Direct color: unpack, advance and repack each channel; select the final color
    always_comb begin
        rw    = gtpg_pkg::chan_width(chw_reg[11:8]);
        gw    = gtpg_pkg::chan_width(chw_reg[7:4]);
        bw    = gtpg_pkg::chan_width(chw_reg[3:0]);
        sh_g  = 5'(bw);
        sh_r  = 5'(gw) + 5'(bw);
        r0    = HW'(first_reg >> sh_r) & gtpg_pkg::chan_mask(rw);
        g0    = HW'(first_reg >> sh_g) & gtpg_pkg::chan_mask(gw);
        b0    = first_reg[HW-1:0] & gtpg_pkg::chan_mask(bw);
        r_val = (r0 + p1_reg) & gtpg_pkg::chan_mask(rw);
        g_val = (g0 + p2_reg) & gtpg_pkg::chan_mask(gw);
        b_val = (b0 + p1_reg + p2_reg) & gtpg_pkg::chan_mask(bw);
        rgb_color = (KW'(r_val) << sh_r) | (KW'(g_val) << sh_g) | KW'(b_val);
        if (!inside_reg) begin
            color_val = '0;
        end else if (indexed_reg) begin
            color_val = KW'(idx_sum);
        end else begin
            color_val = rgb_color;
        end
    end

    // Raster position: clear at frame start, advance when the pixel leaves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            ox_reg  <= '0;
            oy_reg  <= '0;
            gc_reg  <= '0;
            gr_reg  <= '0;
        end else if (state_reg == ST_IDLE && accept && at_origin) begin
            col_reg <= '0;
            row_reg <= '0;
            ox_reg  <= '0;
            oy_reg  <= '0;
            gc_reg  <= '0;
            gr_reg  <= '0;
        end else if (state_reg == ST_FIN && out_free) begin
            if (lend) begin
                col_reg <= '0;
                ox_reg  <= '0;
                gc_reg  <= '0;
                if (fend) begin
                    row_reg <= '0;
                    oy_reg  <= '0;
                    gr_reg  <= '0;
                end else begin
                    row_reg <= row_reg + 1'b1;
                    if (oy_inc >= ch_reg) begin
                        oy_reg <= '0;
                        if (gr_reg != '1) begin
                            gr_reg <= gr_reg + 1'b1;
                        end
                    end else begin
                        oy_reg <= oy_inc;
                    end
                end
            end else begin
                col_reg <= col_reg + 1'b1;
                if (ox_inc >= cw_reg) begin
                    ox_reg <= '0;
                    if (gc_reg != '1) begin
                        gc_reg <= gc_reg + 1'b1;
                    end
                end else begin
                    ox_reg <= ox_inc;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            out_x_reg      <= col_reg;
            out_y_reg      <= row_reg;
            out_color_reg  <= color_val;
            out_inside_reg <= inside_reg;
            out_lend_reg   <= lend;
            out_fend_reg   <= fend;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_color_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_lend_reg;
    assign m_tuser  = {out_fend_reg, out_inside_reg};

    // Checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    a_load_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("output loaded outside the final step");

    a_black_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[45:22] == '0)
        else $error("pixel outside the grid is not black");

    a_frame_end_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("frame end without line end");

    a_unit_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_rsp.done |-> (state_reg == ST_DIV_W || state_reg == ST_DIV_H ||
                           state_reg == ST_MUL_A || state_reg == ST_MUL_B))
        else $error("unit finished while the sequencer was not waiting");

endmodule
